>>> rtl/ole_pkg.sv
package ole_pkg;

    localparam int CAPACITY_DEF    = 32;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int CAPACITY_MAX    = 256;
    localparam int CNT_BITS        = $clog2(CAPACITY_MAX + 1);
    localparam int TYPE_BITS       = 3;
    localparam int POS_BITS        = 6;
    localparam int VALUE_BITS      = 16;
    localparam int STATUS_BITS     = 2;
    localparam int LEN_BITS        = 6;
    localparam int OP_BITS         = 3;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [TYPE_BITS-1:0] REQ_APPEND  = 3'd0;
    localparam logic [TYPE_BITS-1:0] REQ_DELETE  = 3'd1;
    localparam logic [TYPE_BITS-1:0] REQ_REVERSE = 3'd2;
    localparam logic [TYPE_BITS-1:0] REQ_MOVE    = 3'd3;
    localparam logic [TYPE_BITS-1:0] REQ_SIZE    = 3'd4;
    localparam logic [TYPE_BITS-1:0] REQ_LIST    = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd3;

    localparam logic [OP_BITS-1:0] OP_REPORT  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_APPEND  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_DELETE  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_REVERSE = 3'd3;
    localparam logic [OP_BITS-1:0] OP_MOVE    = 3'd4;
    localparam logic [OP_BITS-1:0] OP_LIST    = 3'd5;

    typedef struct packed {
        logic [TYPE_BITS-1:0]  req_type;
        logic [POS_BITS-1:0]   position;
        logic [VALUE_BITS-1:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [LEN_BITS-1:0]    list_length;
        logic [VALUE_BITS-1:0]  entry_out;
        logic [LEN_BITS-1:0]    entry_index;
        logic                   last;
    } rsp_t;

    typedef struct packed {
        logic [OP_BITS-1:0]     op;
        logic [STATUS_BITS-1:0] status;
        logic [CNT_BITS-1:0]    first;
        logic [CNT_BITS-1:0]    length;
        logic [VALUE_BITS-1:0]  value;
    } cmd_t;

endpackage

>>> rtl/ole_queue.sv
module ole_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ole_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output ole_pkg::cmd_t pop_data,
    output logic          empty
);

    localparam int DEPTH = ole_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);

    ole_pkg::cmd_t        entries_reg [DEPTH];
    logic [PW-1:0]        wr_ptr_reg;
    logic [PW-1:0]        rd_ptr_reg;
    logic [FW-1:0]        fill_reg;
    logic [PW-1:0]        wr_ptr_next;
    logic [PW-1:0]        rd_ptr_next;
    logic [FW-1:0]        fill_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (fill_reg == FW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/ole_front.sv
module ole_front
#(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ole_pkg::req_t req,
    output logic          q_push,
    output ole_pkg::cmd_t q_data,
    input  logic          q_full
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CNB = ole_pkg::CNT_BITS;

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [CNB-1:0] cnt;
    logic [CNB-1:0] pos;
    logic [CNB-1:0] cap;
    logic [CNB-1:0] n_list;
    logic           pos_bad;

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

    always_comb
    begin
        cnt     = CNB'(count_reg);
        pos     = CNB'(req.position);
        cap     = CNB'(CAPACITY);
        pos_bad = (pos == '0) || (pos > cnt);
        n_list  = (pos < cnt) ? pos : cnt;

        q_data.op     = ole_pkg::OP_REPORT;
        q_data.status = ole_pkg::ST_OK;
        q_data.first  = '0;
        q_data.length = cnt;
        q_data.value  = req.entry_value;

        case (req.req_type)
            ole_pkg::REQ_APPEND:
            begin
                if (cnt >= cap)
                begin
                    q_data.status = ole_pkg::ST_FULL;
                end
                else
                begin
                    q_data.op     = ole_pkg::OP_APPEND;
                    q_data.first  = cnt;
                    q_data.length = cnt + CNB'(1);
                end
            end
            ole_pkg::REQ_DELETE:
            begin
                if (pos_bad)
                begin
                    q_data.status = ole_pkg::ST_BAD_POS;
                end
                else
                begin
                    q_data.op     = ole_pkg::OP_DELETE;
                    q_data.first  = pos - CNB'(1);
                    q_data.length = cnt - CNB'(1);
                end
            end
            ole_pkg::REQ_REVERSE:
            begin
                if (cnt > CNB'(1))
                begin
                    q_data.op    = ole_pkg::OP_REVERSE;
                    q_data.first = cnt - CNB'(1);
                end
            end
            ole_pkg::REQ_MOVE:
            begin
                if (pos_bad)
                begin
                    q_data.status = ole_pkg::ST_BAD_POS;
                end
                else if (pos != CNB'(1))
                begin
                    q_data.op    = ole_pkg::OP_MOVE;
                    q_data.first = pos - CNB'(1);
                end
            end
            ole_pkg::REQ_LIST:
            begin
                if (n_list == '0)
                begin
                    q_data.status = ole_pkg::ST_EMPTY;
                end
                else
                begin
                    q_data.op    = ole_pkg::OP_LIST;
                    q_data.first = n_list;
                end
            end
            default:
            begin
                q_data.op = ole_pkg::OP_REPORT;
            end
        endcase

        count_next = q_push ? CW'(q_data.length) : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/ole_back.sv
module ole_back
#(
    parameter int CAPACITY    = ole_pkg::CAPACITY_DEF,
    parameter int HANDLE_BITS = ole_pkg::HANDLE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    output logic          q_pop,
    input  ole_pkg::cmd_t q_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ole_pkg::rsp_t rsp
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int VB  = ole_pkg::VALUE_BITS;
    localparam int LB  = ole_pkg::LEN_BITS;
    localparam int SW  = (HANDLE_BITS < VB) ? HANDLE_BITS : VB;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EMIT    = 4'd1;
    localparam logic [3:0] S_DEL_RD  = 4'd2;
    localparam logic [3:0] S_DEL_WR  = 4'd3;
    localparam logic [3:0] S_MV_RD0  = 4'd4;
    localparam logic [3:0] S_MV_CAP  = 4'd5;
    localparam logic [3:0] S_MV_RD   = 4'd6;
    localparam logic [3:0] S_MV_WR   = 4'd7;
    localparam logic [3:0] S_MV_FIN  = 4'd8;
    localparam logic [3:0] S_RV_RDA  = 4'd9;
    localparam logic [3:0] S_RV_RDB  = 4'd10;
    localparam logic [3:0] S_RV_WRA  = 4'd11;
    localparam logic [3:0] S_RV_WRB  = 4'd12;
    localparam logic [3:0] S_LS_RD   = 4'd13;
    localparam logic [3:0] S_LS_EM   = 4'd14;

    logic [SW-1:0]  slots_mem [CAPACITY];

    logic [3:0]     state_reg;
    logic [3:0]     state_next;
    ole_pkg::cmd_t  cur_reg;
    ole_pkg::cmd_t  cur_next;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  idx_next;
    logic [CW-1:0]  aux_reg;
    logic [CW-1:0]  aux_next;
    logic [CW-1:0]  idx_inc;
    logic [CW-1:0]  idx_dec;
    logic [SW-1:0]  hold_reg;
    logic [SW-1:0]  hold_next;
    logic [SW-1:0]  rdata_reg;
    logic           out_valid_reg;
    ole_pkg::rsp_t  out_reg;
    ole_pkg::rsp_t  out_next;
    logic           out_load;
    logic           out_free;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [SW-1:0]  mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign idx_inc   = idx_reg + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        aux_next   = aux_reg;
        hold_next  = hold_reg;
        out_next   = out_reg;
        out_load   = 1'b0;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_data;
                    idx_next = CW'(q_data.first);
                    aux_next = CW'(q_data.first);
                    case (q_data.op)
                        ole_pkg::OP_APPEND:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(q_data.first);
                            mem_wdata  = q_data.value[SW-1:0];
                            state_next = S_EMIT;
                        end
                        ole_pkg::OP_DELETE:
                        begin
                            if (CW'(q_data.first) < CW'(q_data.length))
                            begin
                                state_next = S_DEL_RD;
                            end
                            else
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        ole_pkg::OP_REVERSE:
                        begin
                            idx_next   = '0;
                            state_next = S_RV_RDA;
                        end
                        ole_pkg::OP_MOVE:
                        begin
                            state_next = S_MV_RD0;
                        end
                        ole_pkg::OP_LIST:
                        begin
                            idx_next   = '0;
                            state_next = S_LS_RD;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_DEL_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_inc[AW-1:0];
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = rdata_reg;
                idx_next  = idx_inc;
                if (idx_inc >= CW'(cur_reg.length))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_DEL_RD;
                end
            end
            S_MV_RD0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[AW-1:0];
                state_next = S_MV_CAP;
            end
            S_MV_CAP:
            begin
                hold_next  = rdata_reg;
                mem_re     = 1'b1;
                mem_raddr  = idx_dec[AW-1:0];
                state_next = S_MV_WR;
            end
            S_MV_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_dec[AW-1:0];
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = rdata_reg;
                idx_next  = idx_dec;
                if (idx_dec == '0)
                begin
                    state_next = S_MV_FIN;
                end
                else
                begin
                    state_next = S_MV_RD;
                end
            end
            S_MV_FIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = hold_reg;
                state_next = S_EMIT;
            end
            S_RV_RDA:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[AW-1:0];
                state_next = S_RV_RDB;
            end
            S_RV_RDB:
            begin
                hold_next  = rdata_reg;
                mem_re     = 1'b1;
                mem_raddr  = aux_reg[AW-1:0];
                state_next = S_RV_WRA;
            end
            S_RV_WRA:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = rdata_reg;
                state_next = S_RV_WRB;
            end
            S_RV_WRB:
            begin
                mem_we    = 1'b1;
                mem_waddr = aux_reg[AW-1:0];
                mem_wdata = hold_reg;
                idx_next  = idx_inc;
                aux_next  = aux_reg - CW'(1);
                if (idx_inc < aux_reg - CW'(1))
                begin
                    state_next = S_RV_RDA;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_LS_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[AW-1:0];
                state_next = S_LS_EM;
            end
            S_LS_EM:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    out_next.status      = ole_pkg::ST_OK;
                    out_next.list_length = LB'(cur_reg.length);
                    out_next.entry_out   = VB'(rdata_reg);
                    out_next.entry_index = LB'(idx_inc);
                    out_next.last        = (idx_inc == aux_reg);
                    idx_next             = idx_inc;
                    if (idx_inc == aux_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LS_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    out_next.status      = cur_reg.status;
                    out_next.list_length = LB'(cur_reg.length);
                    out_next.entry_out   = '0;
                    out_next.entry_index = '0;
                    out_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        idx_reg  <= idx_next;
        aux_reg  <= aux_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slots_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= slots_mem[mem_raddr];
        end
    end

endmodule

>>> rtl/ordered_list_engine.sv
// Bounded ordered list of entry handles with append, delete, reverse, move to front, size and
// listing requests. A front stage checks each request against its own copy of the list length
// and queues a decoded command, and a back stage carries it out on a single-port list memory
// and drives the response register. Append writes one slot and report-only requests touch
// no slot; delete moves each later entry one place down, move to front shifts each earlier
// entry one place up and writes the moved entry at the front, reverse reads and writes both
// entries of each swapped pair, and a listing reads and emits each listed entry. The list
// memory takes one access, a read or a write, per cycle, with its read data registered. The
// queue lets two further requests be taken while a command is still being worked on.
module ordered_list_engine
#(
    parameter int CAPACITY    = ole_pkg::CAPACITY_DEF,
    parameter int HANDLE_BITS = ole_pkg::HANDLE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ole_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ole_pkg::rsp_t rsp
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    ole_pkg::cmd_t q_in;
    ole_pkg::cmd_t q_out;

    ole_front
    #(
        .CAPACITY (CAPACITY)
    )
    u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    ole_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    ole_back
    #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_out),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
